/* design/modexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by modexp_mulmod, modular_exponentiation, modexp_checker and the testbench top.
package modexp_pkg;

    // Operand width of base, exponent, modulus and result.
    localparam int WIDTH = 32;
    // Width of the bit counter inside the serial multiplier.
    localparam int CNT_W = $clog2(WIDTH);
    // Modulus held after reset.
    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(15588119);

    // Request from the sequencer to the shared modular multiplier.
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] m;
    } t_mm_req;

    // Status and product returned by the modular multiplier.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIDTH-1:0] product;
    } t_mm_rsp;

endpackage

/* design/modexp_mulmod.sv */
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
// Depends on modexp_pkg for WIDTH, CNT_W and the request/response structs.
module modexp_mulmod import modexp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mm_req i_req,
    output t_mm_rsp o_rsp
);

    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_mod;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   w_dbl;
    logic [WIDTH-1:0] w_dbl_red;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH-1:0] w_sum_red;

    // One step: double the accumulator modulo m, then add a if the current bit of b is set.
    // Both accumulator and a stay below m, so one conditional subtract suffices each time.
    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_mod}) ? WIDTH'(w_dbl - {1'b0, r_mod})
                                             : w_dbl[WIDTH-1:0];
        w_sum     = {1'b0, w_dbl_red} + {1'b0, r_a};
        w_sum_red = (w_sum >= {1'b0, r_mod}) ? WIDTH'(w_sum - {1'b0, r_mod})
                                             : w_sum[WIDTH-1:0];
        n_acc     = r_b[WIDTH-1] ? w_sum_red : w_dbl_red;
    end

    // Operand capture, bit counter and completion strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_acc  <= '0;
                    r_a    <= i_req.a;
                    r_b    <= i_req.b;
                    r_mod  <= i_req.m;
                    r_cnt  <= CNT_W'(WIDTH - 1);
                end
            end else begin
                r_acc <= n_acc;
                r_b   <= {r_b[WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

/* design/modular_exponentiation.sv */
// Top level of the modular exponentiation block: sequencer around one shared multiplier.
// Depends on modexp_pkg and modexp_mulmod.
//
//  Channel  | Ports                                    | Handshake
//  ---------+------------------------------------------+---------------------------------
//  command  | i_start, o_busy, i_base_value, i_exponent | beat taken when i_start && !o_busy
//  result   | o_done, o_power_result                   | one-cycle strobe, no back-pressure
//  config   | i_cfg_we, i_cfg_data                     | modulus written when i_cfg_we high
//
// Every product, including the initial reduction of the base, runs through the one
// bit-serial modular multiplier. A beat costs one reduction, then per exponent bit up
// to the highest set bit a pass through the check state, a square and, for a set bit,
// a multiply, plus one final check before the result strobe. A modulus below two is
// answered with zero at once, without using the multiplier.
// Reset is synchronous and active low and restores the modulus to its reset value.
// The receiver cannot stall: the result is shown for exactly one cycle.
module modular_exponentiation import modexp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [WIDTH-1:0] i_base_value,
    input  logic [WIDTH-1:0] i_exponent,
    output logic             o_done,
    output logic [WIDTH-1:0] o_power_result,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_CHECK,
        S_MUL,
        S_SQR
    } t_state;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_mod, n_mod;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic [WIDTH-1:0] r_res, n_res;
    logic [WIDTH-1:0] r_pw, n_pw;
    logic             r_done, n_done;
    logic [WIDTH-1:0] r_out, n_out;
    t_mm_req          r_req, n_req;
    t_mm_rsp          w_rsp;

    logic w_accept;

    assign w_accept = i_start && (r_state == S_IDLE);

    // Shared modular multiplier.
    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer: zero for a modulus below two; else reduce the base, scan the exponent from bit 0.
    always_comb begin
        n_state   = r_state;
        n_mod     = r_mod;
        n_exp     = r_exp;
        n_res     = r_res;
        n_pw      = r_pw;
        n_done    = 1'b0;
        n_out     = r_out;
        n_req     = r_req;
        n_req.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mod = r_modulus;
                    n_exp = i_exponent;
                    n_res = WIDTH'(1);
                    if (r_modulus < WIDTH'(2)) begin
                        // Degenerate modulus: answer zero at once.
                        n_done = 1'b1;
                        n_out  = '0;
                    end else begin
                        // Base mod m is computed as 1 * base mod m.
                        n_req   = '{start: 1'b1, a: WIDTH'(1), b: i_base_value, m: r_modulus};
                        n_state = S_BASE;
                    end
                end
            end
            S_BASE: begin
                if (w_rsp.done) begin
                    n_pw    = w_rsp.product;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_exp == '0) begin
                    n_done  = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end else if (r_exp[0]) begin
                    n_req   = '{start: 1'b1, a: r_res, b: r_pw, m: r_mod};
                    n_state = S_MUL;
                end else begin
                    n_req   = '{start: 1'b1, a: r_pw, b: r_pw, m: r_mod};
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (w_rsp.done) begin
                    n_res   = w_rsp.product;
                    n_req   = '{start: 1'b1, a: r_pw, b: r_pw, m: r_mod};
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (w_rsp.done) begin
                    n_pw    = w_rsp.product;
                    n_exp   = {1'b0, r_exp[WIDTH-1:1]};
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_modulus <= MODULUS_RESET;
            r_done    <= 1'b0;
            r_req     <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_req   <= n_req;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_data;
            end
        end
        r_mod <= n_mod;
        r_exp <= n_exp;
        r_res <= n_res;
        r_pw  <= n_pw;
        r_out <= n_out;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_power_result = r_out;

    // A degenerate modulus gives a zero result in the very next cycle.
    a_small_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_modulus < WIDTH'(2))) |=> (o_done && (o_power_result == '0)))
        else $error("modulus below two did not give an immediate zero result");

    // Every delivered result is reduced below the modulus in use, unless that modulus is below two.
    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_power_result < r_mod) || (r_mod < WIDTH'(2))))
        else $error("result not reduced by the modulus");

    // The multiplier finishes only while the sequencer waits for it.
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> ((r_state == S_BASE) || (r_state == S_MUL) || (r_state == S_SQR)))
        else $error("multiplier finished outside a waiting state");

    // A product is launched only when the multiplier is free.
    a_launch_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> !w_rsp.busy)
        else $error("multiplier launched while busy");

endmodule

/* tb/modexp_checker.sv */
// Checker for the modular exponentiation block: watches the command, result and
// modulus write channels, predicts each power and compares it with the result strobe.
// Depends on modexp_pkg for WIDTH and MODULUS_RESET.
module modexp_checker import modexp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [WIDTH-1:0] i_base_value,
    input  logic [WIDTH-1:0] i_exponent,
    input  logic             i_done,
    input  logic [WIDTH-1:0] i_power_result,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_data,
    output int               o_mismatch_count,
    output int               o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Own copy of the modulus register and the powers still owed by the block.
    logic [WIDTH-1:0] modulus_shadow;
    logic [WIDTH-1:0] expected_powers[$];
    logic [WIDTH-1:0] oldest_power;
    int               mismatches = 0;

    // Modular add of two operands that are already below the modulus.
    // One spare bit holds the carry, so the sum never wraps.
    function automatic logic [WIDTH-1:0] add_reduced(input logic [WIDTH-1:0] x,
                                                     input logic [WIDTH-1:0] y,
                                                     input logic [WIDTH-1:0] m);
        logic [WIDTH:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, m}) begin
            sum = sum - {1'b0, m};
        end
        return sum[WIDTH-1:0];
    endfunction

    // Shift-and-add product, scanning the multiplier from its top bit.
    function automatic logic [WIDTH-1:0] mul_reduced(input logic [WIDTH-1:0] a,
                                                     input logic [WIDTH-1:0] b,
                                                     input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] acc;
        acc = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            acc = add_reduced(acc, acc, m);
            if (b[i]) begin
                acc = add_reduced(acc, a, m);
            end
        end
        return acc;
    endfunction

    // Right-to-left square-and-multiply. A modulus below two always gives zero,
    // otherwise a zero exponent gives one whatever the base.
    function automatic logic [WIDTH-1:0] power_mod(input logic [WIDTH-1:0] base,
                                                   input logic [WIDTH-1:0] expo,
                                                   input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] square;
        logic [WIDTH-1:0] result;
        if (m < WIDTH'(2)) begin
            return '0;
        end
        square = base % m;
        result = WIDTH'(1);
        for (int i = 0; i < WIDTH; i++) begin
            if (expo[i]) begin
                result = mul_reduced(result, square, m);
            end
            square = mul_reduced(square, square, m);
        end
        return result;
    endfunction

    // A command beat is predicted with the modulus in force at its edge; a modulus
    // write at the same edge only affects later beats. Results are checked in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_shadow = MODULUS_RESET;
            expected_powers.delete();
        end else begin
            if (i_start && !i_busy) begin
                expected_powers.push_back(power_mod(i_base_value, i_exponent, modulus_shadow));
            end
            if (i_cfg_we) begin
                modulus_shadow = i_cfg_data;
            end
            if (i_done) begin
                if (expected_powers.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("power_result strobe with no beat outstanding: got %h",
                                 i_power_result);
                    end
                    mismatches++;
                end else begin
                    oldest_power = expected_powers.pop_front();
                    if (i_power_result !== oldest_power) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("power_result mismatch: expected %h, got %h",
                                     oldest_power, i_power_result);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_pending        <= expected_powers.size();
    end

endmodule

/* tb/tb_modular_exponentiation.sv */
// Testbench top for the modular exponentiation block: clock, reset, command beats and
// modulus writes, with the verdict taken from the checker. Depends on modexp_pkg,
// modular_exponentiation and modexp_checker.
module tb_modular_exponentiation;
    import modexp_pkg::*;

    localparam int RANDOM_PHASES   = 10;
    localparam int BEATS_PER_PHASE = 56;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 2200;
    localparam int RUN_LIMIT       = 25_000_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    logic [WIDTH-1:0] i_base_value;
    logic [WIDTH-1:0] i_exponent;
    logic             o_done;
    logic [WIDTH-1:0] o_power_result;
    logic             i_cfg_we;
    logic [WIDTH-1:0] i_cfg_data;
    int               mismatch_count;
    int               pending_powers;
    logic             gaps_enabled;
    logic             all_drained;
    logic [WIDTH-1:0] phase_modulus;

    modular_exponentiation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_done         (o_done),
        .o_power_result (o_power_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    modexp_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_base_value     (i_base_value),
        .i_exponent       (i_exponent),
        .i_done           (o_done),
        .i_power_result   (o_power_result),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_powers)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Present one command beat, after an optional burst of idle cycles, and hold it
    // until it is taken. Entered and left just after a falling edge; start stays high
    // on exit so that back-to-back beats never drop it.
    task automatic send_beat(input logic [WIDTH-1:0] base, input logic [WIDTH-1:0] expo);
        int gap;
        gap = 0;
        if (gaps_enabled && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start      = 1'b1;
        i_base_value = base;
        i_exponent   = expo;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    // Stop issuing beats and wait, within a bound, until every result has come back.
    task automatic drain_results();
        int waited;
        waited = 0;
        i_start = 1'b0;
        while (pending_powers != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_powers != 0) begin
            all_drained = 1'b0;
        end
    endtask

    // Single-cycle write of the modulus register while the block is idle.
    task automatic write_modulus(input logic [WIDTH-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Exponent with a random bit length, so that both short and long scans occur;
    // now and then a fully random word.
    function automatic logic [WIDTH-1:0] pick_exponent();
        logic [WIDTH-1:0] expo;
        int               len;
        expo = $urandom();
        if ($urandom_range(0, 7) == 0) begin
            return expo;
        end
        len = $urandom_range(0, WIDTH);
        if (len == 0) begin
            return '0;
        end
        if (len < WIDTH) begin
            expo = expo & ((WIDTH'(1) << len) - WIDTH'(1));
        end
        expo[len-1] = 1'b1;
        return expo;
    endfunction

    // Base mixing edge values, values already below the modulus and raw words.
    function automatic logic [WIDTH-1:0] pick_base(input logic [WIDTH-1:0] m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WIDTH'(1);
            2: return m - WIDTH'(1);
            3: return m;
            4: return '1;
            5, 6: begin
                if (m >= WIDTH'(2)) begin
                    return $urandom_range(0, m - WIDTH'(1));
                end
                return $urandom();
            end
            default: return $urandom();
        endcase
    endfunction

    // Modulus for each random phase: the largest values, a power of two, tiny and
    // mid-sized moduli, random words and a return to the reset value.
    function automatic logic [WIDTH-1:0] pick_modulus(input int phase);
        case (phase)
            0: return 32'hFFFF_FFFB;
            1: return 32'h8000_0000;
            2: return WIDTH'(3);
            3: return $urandom_range(2, 255);
            4: return $urandom_range(256, 65535);
            5: return $urandom() | 32'h8000_0000;
            6: return 32'h8000_0001;
            7: return $urandom() | WIDTH'(2);
            8: return MODULUS_RESET;
            default: return '1;
        endcase
    endfunction

    // Stimulus: reset, a directed part per modulus, then random phases.
    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_base_value = '0;
        i_exponent   = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        gaps_enabled = 1'b1;
        all_drained  = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Modulus from reset: zero exponent with base zero, base equal to and just
        // below the modulus, extreme and alternating bit patterns.
        send_beat('0, '0);
        send_beat('0, WIDTH'(5));
        send_beat(WIDTH'(1), '1);
        send_beat('1, '1);
        send_beat('1, '0);
        send_beat(MODULUS_RESET, WIDTH'(3));
        send_beat(MODULUS_RESET - WIDTH'(1), WIDTH'(2));
        send_beat(32'hAAAA_AAAA, 32'h5555_5555);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA);
        send_beat(32'h1234_5678, 32'h8000_0000);
        drain_results();

        // Moduli below two answer zero for every beat, even a zero exponent.
        write_modulus('0);
        send_beat(WIDTH'(7), WIDTH'(3));
        send_beat('0, '0);
        drain_results();
        write_modulus(WIDTH'(1));
        send_beat('1, '1);
        send_beat(WIDTH'(5), '0);
        drain_results();

        // Smallest and largest proper moduli.
        write_modulus(WIDTH'(2));
        send_beat(WIDTH'(3), '1);
        send_beat('1, WIDTH'(2));
        send_beat(WIDTH'(2), '0);
        drain_results();
        write_modulus('1);
        send_beat(32'hFFFF_FFFE, '1);
        send_beat('1, WIDTH'(5));
        send_beat(32'hFFFF_FFFE, WIDTH'(2));
        drain_results();

        // Random phases; the last one runs without idle cycles.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            phase_modulus = pick_modulus(phase);
            gaps_enabled  = (phase != RANDOM_PHASES - 1);
            write_modulus(phase_modulus);
            for (int beat = 0; beat < BEATS_PER_PHASE; beat++) begin
                send_beat(pick_base(phase_modulus), pick_exponent());
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (all_drained && mismatch_count == 0 && pending_powers == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/modexp_pkg.sv
design/modexp_mulmod.sv
design/modular_exponentiation.sv
tb/modexp_checker.sv
tb/tb_modular_exponentiation.sv
